>>> rtl/ptd_pkg.sv
package ptd_pkg;

  localparam int NUM_TASKS  = 6;
  localparam int TASK_SLOTS = 6;
  localparam int TASK_IDX_W = 3;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [INTERVAL_W-1:0] interval_t;
  typedef logic [TASK_IDX_W-1:0] task_idx_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // register map
  localparam cfg_idx_t REG_ENABLE_MASK   = 3'd0;
  localparam cfg_idx_t REG_INTERVAL_BASE = 3'd1;

  localparam logic [TASK_SLOTS-1:0] ENABLE_RESET = 6'd63;

  localparam interval_t INTERVAL_RESET [TASK_SLOTS] =
    '{16'd2, 16'd100, 16'd1000, 16'd10, 16'd1, 16'd500};

  localparam time_t LAST_RUN_RESET [TASK_SLOTS] =
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd200};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic hit_commit;
    logic miss_commit;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic at_end;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/ptd_ctrl.sv
module ptd_ctrl
  import ptd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.hit || stat.at_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    cmd             = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.hit_commit  = stat.hit;
        cmd.miss_commit = !stat.hit && stat.at_end;
        cmd.advance     = !stat.hit && !stat.at_end;
      end
      ST_EMIT: begin
        cmd.emit = !stat.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/ptd_dp.sv
module ptd_dp
  import ptd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  time_t                 in_now_ms,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  out_task_due,
  output task_idx_t             out_task_index
);

  logic [TASK_SLOTS-1:0] enable_r;
  interval_t             interval_r [TASK_SLOTS];
  time_t                 last_run_r [TASK_SLOTS];
  time_t                 launch_r;
  logic                  launched_r;
  task_idx_t             resume_r;
  time_t                 rel_r;
  time_t                 rel_nxt;
  task_idx_t             idx_r;
  logic                  res_due_r;
  task_idx_t             res_idx_r;
  logic                  out_valid_r;
  logic                  out_due_r;
  task_idx_t             out_idx_r;

  logic      in_range;
  task_idx_t sel;
  time_t     elapsed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= ENABLE_RESET;
      for (int k = 0; k < TASK_SLOTS; k++) begin
        interval_r[k] <= INTERVAL_RESET[k];
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_ENABLE_MASK) begin
        enable_r <= cfg_data[TASK_SLOTS-1:0];
      end
      for (int k = 0; k < TASK_SLOTS; k++) begin
        if (cfg_index == REG_INTERVAL_BASE + CFG_IDX_W'(k)) begin
          interval_r[k] <= cfg_data[INTERVAL_W-1:0];
        end
      end
    end
  end

  // scan compare
  assign in_range = idx_r < TASK_IDX_W'(NUM_TASKS);
  assign sel      = in_range ? idx_r : '0;
  assign elapsed  = rel_r - last_run_r[sel];

  assign stat.hit      = in_range && enable_r[sel] &&
                         (elapsed > {{(TIME_W-INTERVAL_W){1'b0}}, interval_r[sel]});
  assign stat.at_end   = idx_r >= TASK_IDX_W'(NUM_TASKS - 1);
  assign stat.out_busy = out_valid_r && out_stall;

  assign rel_nxt = launched_r ? (in_now_ms - launch_r) : '0;

  // scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r   <= '0;
      launched_r <= 1'b0;
      resume_r   <= '0;
      for (int k = 0; k < TASK_SLOTS; k++) begin
        last_run_r[k] <= LAST_RUN_RESET[k];
      end
    end else begin
      if (cmd.load && !launched_r) begin
        launch_r   <= in_now_ms;
        launched_r <= 1'b1;
      end
      if (cmd.hit_commit) begin
        last_run_r[sel] <= rel_r;
        resume_r        <= idx_r;
      end else if (cmd.miss_commit) begin
        resume_r <= '0;
      end
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rel_r <= rel_nxt;
      idx_r <= resume_r;
    end else if (cmd.advance) begin
      idx_r <= idx_r + TASK_IDX_W'(1);
    end
    if (cmd.hit_commit) begin
      res_due_r <= 1'b1;
      res_idx_r <= idx_r;
    end else if (cmd.miss_commit) begin
      res_due_r <= 1'b0;
      res_idx_r <= '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_due_r <= res_due_r;
      out_idx_r <= res_idx_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_task_due   = out_due_r;
  assign out_task_index = out_idx_r;

endmodule

>>> rtl/periodic_task_dispatcher.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    in_now_ms[31:0]
// out      output     out_valid/out_stall  out_task_due, out_task_index[2:0]
// cfg      input      cfg_we               cfg_index[2:0], cfg_data[15:0]
//
// a poll steps through accept, a scan that visits the tasks in order (1 to 6,
// set by the single shared elapsed-time compare and the last task), then emit
// polls are taken one at a time; in_stall is high from accept until the word
// has moved into the output register
// out_stall holds the output word and, once the next scan ends, the input side
// reset is synchronous and active low; no clearing pass is needed
module periodic_task_dispatcher
  import ptd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_task_due,
  output logic [TASK_IDX_W-1:0] out_task_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_now_ms      (in_now_ms),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_task_due   (out_task_due),
    .out_task_index (out_task_index)
  );

endmodule

>>> rtl/ptd_chk.sv
module ptd_chk
  import ptd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_task_due,
  input logic [TASK_IDX_W-1:0] out_task_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_task_due) && $stable(out_task_index))
    else $error("output word changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_task_due |-> out_task_index == '0)
    else $error("index nonzero with no task due");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_task_index < TASK_IDX_W'(NUM_TASKS))
    else $error("task index out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted during scan");

endmodule

bind periodic_task_dispatcher ptd_chk u_ptd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_task_due   (out_task_due),
  .out_task_index (out_task_index)
);
